@@ sv/bkc_pkg.sv @@
// Package for the binary k-gram coverage check.
// Holds widths, the result record and the configuration register offsets.
// No dependencies.
`default_nettype none

package bkc_pkg;

    localparam int MAX_CODE_LEN_DEF = 10;
    localparam int CODE_LEN_W       = 4;
    localparam int DISTINCT_W       = 11;
    localparam int EPOCH_W          = 8;
    localparam int OUT_FIFO_DEPTH   = 4;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int CODE_LEN_RESET   = 1;

    localparam logic [APB_ADDR_W-1:0] REG_CODE_LENGTH = APB_ADDR_W'(0);

    typedef struct packed {
        logic                  all_present;
        logic [DISTINCT_W-1:0] distinct_found;
    } result_t;

endpackage

`default_nettype wire

@@ sv/bkc_if.sv @@
// Handshake channel interfaces for the binary k-gram coverage check.
// Depends on bkc_pkg for the result width.
`default_nettype none

interface bkc_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic end_of_string;

    modport source (output valid, output data_bit, output end_of_string, input ready);
    modport sink (input valid, input data_bit, input end_of_string, output ready);
endinterface

interface bkc_out_if import bkc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  all_present;
    logic [DISTINCT_W-1:0] distinct_found;

    modport source (output valid, output all_present, output distinct_found, input ready);
    modport sink (input valid, input all_present, input distinct_found, output ready);
endinterface

`default_nettype wire

@@ sv/bkc_tag_mem.sv @@
// Tag memory of the seen map: one epoch tag per k-bit code.
// One write and one registered read per cycle. Uses bkc_pkg.
`default_nettype none

module bkc_tag_mem import bkc_pkg::*;
#(
    parameter int ADDR_W = MAX_CODE_LEN_DEF
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [EPOCH_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [EPOCH_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [EPOCH_W-1:0] mem [DEPTH];
    logic [EPOCH_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/bkc_cfg.sv @@
// APB register block of the binary k-gram coverage check.
// Holds the code length register. Uses bkc_pkg.
`default_nettype none

module bkc_cfg import bkc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CODE_LEN_W-1:0] code_length
);

    logic [CODE_LEN_W-1:0] code_length_reg;
    logic [CODE_LEN_W-1:0] code_length_next;
    logic                  sel_code_length;

    assign pready          = 1'b1;
    assign sel_code_length = ({paddr[APB_ADDR_W-1:2], 2'b00} == REG_CODE_LENGTH);

    always_comb
    begin
        code_length_next = code_length_reg;
        if (psel && penable && pwrite && pready && sel_code_length)
        begin
            code_length_next = pwdata[CODE_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CODE_LEN_W'(CODE_LEN_RESET);
        end
        else
        begin
            code_length_reg <= code_length_next;
        end
    end

    assign prdata      = sel_code_length ? APB_DATA_W'(code_length_reg) : '0;
    assign code_length = code_length_reg;

endmodule

`default_nettype wire

@@ sv/bkc_out_fifo.sv @@
// Result queue of the binary k-gram coverage check.
// Small register FIFO that decouples result delivery from the pipeline. Uses bkc_pkg.
`default_nettype none

module bkc_out_fifo import bkc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire result_t   push_data,
    bkc_out_if.source      out_ch,
    output logic [$clog2(OUT_FIFO_DEPTH):0] occupancy
);

    localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);

    result_t              entry_reg [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [PTR_W:0]       count_reg;
    logic [PTR_W:0]       count_next;
    logic                 pop;
    result_t              head;

    assign pop  = out_ch.valid && out_ch.ready;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + (PTR_W+1)'(1);
            2'b01:   count_next = count_reg - (PTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.all_present    = head.all_present;
    assign out_ch.distinct_found = head.distinct_found;
    assign occupancy             = count_reg;

endmodule

`default_nettype wire

@@ sv/binary_kgram_coverage_check.sv @@
// Top level of the binary k-gram coverage check.
// Uses bkc_pkg, bkc_if, bkc_cfg, bkc_tag_mem and bkc_out_fifo.
//
//   channel     direction  protocol      payload
//   bits_in     in         valid/ready   data_bit, end_of_string
//   result_out  out        valid/ready   all_present, distinct_found
//   apb         in         APB write/rd  code_length at offset 0
//
// One bit is accepted per clock. A result is written into the output queue at the
// clock edge after the last bit of its string is accepted and is offered from then on.
// After reset, and after every 2^EPOCH_W - 1 strings, a pass clears the tag memory,
// one address after another from address zero, while no bit is accepted.
// Input stalls only while that pass runs or is about to start, or when the result
// queue could overflow.
`default_nettype none

module binary_kgram_coverage_check import bkc_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bkc_in_if.sink                     bits_in,
    bkc_out_if.source                  result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int W       = MAX_CODE_LEN;
    localparam int CNT_W   = MAX_CODE_LEN + 1;
    localparam int OCC_W   = $clog2(OUT_FIFO_DEPTH) + 1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    logic [CODE_LEN_W-1:0] code_length;
    logic [CODE_LEN_W-1:0] k;
    logic [W:0]            one_shift;
    logic [W-1:0]          mask;
    logic                  accept;

    logic [W-1:0]          window_reg;
    logic [W-1:0]          window_next;
    logic [W-1:0]          window_shift;
    logic [CODE_LEN_W-1:0] bits_seen_reg;
    logic [CODE_LEN_W-1:0] bits_seen_next;
    logic [CODE_LEN_W-1:0] bits_seen_step;
    logic                  mark_now;

    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic                  s1_mark_reg;
    logic [W-1:0]          s1_idx_reg;
    logic [CODE_LEN_W-1:0] s1_k_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_upd;
    logic [EPOCH_W-1:0]    epoch_reg;
    logic [EPOCH_W-1:0]    epoch_next;
    logic                  clearing_reg;
    logic                  clearing_next;
    logic [W-1:0]          clr_addr_reg;
    logic [W-1:0]          clr_addr_next;

    logic                  fwd_valid_reg;
    logic [W-1:0]          fwd_addr_reg;
    logic [EPOCH_W-1:0]    fwd_tag_reg;

    logic [EPOCH_W-1:0]    rd_tag;
    logic [EPOCH_W-1:0]    eff_tag;
    logic                  hit;
    logic                  new_code;
    logic                  wrap_pending;

    logic                  mem_wr_en;
    logic [W-1:0]          mem_wr_addr;
    logic [EPOCH_W-1:0]    mem_wr_data;

    logic                  push;
    result_t               push_data;
    logic [OCC_W-1:0]      occupancy;
    logic [OCC_W:0]        pending;
    logic [W:0]            full_count;

    bkc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .code_length (code_length)
    );

    assign k = (32'(code_length) > MAX_CODE_LEN) ? CODE_LEN_W'(MAX_CODE_LEN) : code_length;
    assign one_shift = (W+1)'(1) << k;
    assign mask      = W'(one_shift - (W+1)'(1));

    assign wrap_pending = s1_valid_reg && s1_last_reg && (epoch_reg == EPOCH_LAST);
    assign pending      = (OCC_W+1)'(occupancy) + (OCC_W+1)'(s1_valid_reg && s1_last_reg);
    assign bits_in.ready = !clearing_reg && !wrap_pending
                           && (pending < (OCC_W+1)'(OUT_FIFO_DEPTH));
    assign accept = bits_in.valid && bits_in.ready;

    assign window_shift   = W'({window_reg, bits_in.data_bit}) & mask;
    assign bits_seen_step = (bits_seen_reg < k) ? bits_seen_reg + CODE_LEN_W'(1) : k;
    assign mark_now       = (k != '0) && (bits_seen_step >= k);

    always_comb
    begin
        window_next    = window_reg;
        bits_seen_next = bits_seen_reg;
        if (accept)
        begin
            if (bits_in.end_of_string)
            begin
                window_next    = '0;
                bits_seen_next = '0;
            end
            else
            begin
                window_next    = window_shift;
                bits_seen_next = bits_seen_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            bits_seen_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            bits_seen_reg <= bits_seen_next;
            s1_valid_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= bits_in.end_of_string;
            s1_mark_reg <= mark_now;
            s1_idx_reg  <= window_shift;
            s1_k_reg    <= k;
        end
    end

    bkc_tag_mem #(
        .ADDR_W (W)
    ) u_tag_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (window_shift),
        .rd_data (rd_tag)
    );

    assign eff_tag  = (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg)) ? fwd_tag_reg : rd_tag;
    assign hit      = (eff_tag == epoch_reg);
    assign new_code = s1_valid_reg && s1_mark_reg && !hit;
    assign count_upd = count_reg + CNT_W'(new_code);

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = s1_idx_reg;
        mem_wr_data = epoch_reg;
        if (clearing_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = '0;
        end
        else if (new_code)
        begin
            mem_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        epoch_next    = epoch_reg;
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + W'(1);
            if (clr_addr_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
        else if (s1_valid_reg)
        begin
            count_next = count_upd;
            if (s1_last_reg)
            begin
                count_next = '0;
                if (epoch_reg == EPOCH_LAST)
                begin
                    epoch_next    = EPOCH_W'(1);
                    clearing_next = 1'b1;
                    clr_addr_next = '0;
                end
                else
                begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            epoch_reg     <= EPOCH_W'(1);
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            fwd_valid_reg <= mem_wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= mem_wr_addr;
        fwd_tag_reg  <= mem_wr_data;
    end

    assign full_count               = (W+1)'(1) << s1_k_reg;
    assign push                     = s1_valid_reg && s1_last_reg;
    assign push_data.all_present    = (s1_k_reg != '0) && (count_upd == CNT_W'(full_count));
    assign push_data.distinct_found = DISTINCT_W'(count_upd);

    bkc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_ch    (result_out),
        .occupancy (occupancy)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for binary_kgram_coverage_check: bit strings go in over
// the input channel, and each verdict is compared with a built-in model of the k-gram tracker.
// Depends on bkc_pkg, bkc_in_if and bkc_out_if, and on the block itself.

module testbench import bkc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAP_DEPTH = 1 << MAX_CODE_LEN_DEF;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    bkc_in_if bits_if();
    bkc_out_if res_if();

    binary_kgram_coverage_check uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bits_in    (bits_if),
        .result_out (res_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    logic [CODE_LEN_W-1:0] code_len;
    logic [9:0] win;
    logic [CODE_LEN_W-1:0] fill;
    logic [DISTINCT_W-1:0] n_distinct;
    bit marked [MAP_DEPTH];
    result_t coverage_verdicts [$];

    bit pattern [$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned bits_sent;
    int unsigned strings_sent;
    int unsigned cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d verdicts outstanding.",
                     cycle_count, coverage_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (coverage_verdicts.size() == 0)
            begin
                $error("Unexpected result transaction: all_present=%0b distinct_found=%0d",
                       res_if.all_present, res_if.distinct_found);
                fail_count++;
            end
            else
            begin
                want = coverage_verdicts.pop_front();
                results_checked++;
                if (res_if.all_present !== want.all_present)
                begin
                    $error("all_present: expected %0b, got %0b",
                           want.all_present, res_if.all_present);
                    fail_count++;
                end
                if (res_if.distinct_found !== want.distinct_found)
                begin
                    $error("distinct_found: expected %0d, got %0d",
                           want.distinct_found, res_if.distinct_found);
                    fail_count++;
                end
            end
        end
    end

    function automatic void clear_tracker();
        win = '0;
        fill = '0;
        n_distinct = '0;
        marked = '{default: 1'b0};
    endfunction

    function automatic void count_kgrams(input logic value, input logic last);
        int unsigned k;
        int unsigned w;
        result_t verdict;
        k = (code_len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : code_len;
        w = ((int'(win) << 1) | value) & ((1 << k) - 1);
        win = 10'(w);
        fill = (fill < k) ? fill + 4'd1 : CODE_LEN_W'(k);
        if (k > 0 && fill >= k && !marked[w])
        begin
            marked[w] = 1'b1;
            n_distinct++;
        end
        if (last)
        begin
            verdict.all_present = (k > 0) && (n_distinct == DISTINCT_W'(1 << k));
            verdict.distinct_found = n_distinct;
            coverage_verdicts.push_back(verdict);
            clear_tracker();
        end
    endfunction

    // Prefer-one construction of a cyclic de Bruijn sequence, unrolled from a given
    // rotation so that the linear string holds every k-bit code exactly once.
    function automatic void load_debruijn(input int unsigned k, input int unsigned rot);
        bit used [MAP_DEPTH];
        bit cyc [$];
        int unsigned w;
        int unsigned mask;
        int unsigned span;
        used = '{default: 1'b0};
        mask = (1 << k) - 1;
        span = 1 << k;
        w = 0;
        used[0] = 1'b1;
        repeat (k) cyc.push_back(1'b0);
        while (cyc.size() < span)
        begin
            if (!used[((w << 1) | 1) & mask])
            begin
                w = ((w << 1) | 1) & mask;
                cyc.push_back(1'b1);
            end
            else
            begin
                w = (w << 1) & mask;
                cyc.push_back(1'b0);
            end
            used[w] = 1'b1;
        end
        pattern.delete();
        for (int unsigned i = 0; i < span + k - 1; i++)
            pattern.push_back(cyc[(rot + i) % span]);
    endfunction

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    task automatic settle();
        @(negedge clk);
        bits_if.valid <= 1'b0;
        while (coverage_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_code_length(input logic [CODE_LEN_W-1:0] value);
        settle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_CODE_LENGTH;
        pwdata <= {28'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        code_len = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata[CODE_LEN_W-1:0] !== value)
        begin
            $error("code_length readback: expected %0d, got %0d",
                   value, prdata[CODE_LEN_W-1:0]);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_bit(input logic value, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            bits_if.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        bits_if.valid <= 1'b1;
        bits_if.data_bit <= value;
        bits_if.end_of_string <= last;
        do @(posedge clk); while (bits_if.ready !== 1'b1);
        count_kgrams(value, last);
        bits_sent++;
        if (last)
            strings_sent++;
    endtask

    task automatic send_pattern();
        foreach (pattern[i])
            send_bit(pattern[i], i == pattern.size() - 1);
    endtask

    task automatic test_reset_length();
        pattern = '{1'b0, 1'b1};
        send_pattern();
        pattern = '{1'b1};
        send_pattern();
    endtask

    task automatic test_zero_length();
        set_code_length(4'd0);
        pattern = '{1'b1, 1'b1, 1'b0};
        send_pattern();
    endtask

    task automatic test_length_saturation();
        set_code_length(4'd15);
        pattern = '{1'b1, 1'b0};
        send_pattern();
    endtask

    task automatic test_short_and_full();
        set_code_length(4'd3);
        pattern = '{1'b0, 1'b1};
        send_pattern();
        load_debruijn(3, 0);
        send_pattern();
    endtask

    task automatic test_mid_string_change();
        set_code_length(4'd2);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        set_code_length(4'd1);
        send_bit(1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned extremes [4] = '{1, 10, 0, 15};
        int unsigned ke;
        int unsigned cut;
        int unsigned phase_bits;
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                set_idle_mode(mode);
                set_code_length(CODE_LEN_W'((p == 0) ? extremes[mode] : $urandom_range(1, 6)));
                ke = (code_len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : code_len;
                phase_bits = 0;
                while (phase_bits < 10)
                begin
                    if (ke >= 1 && ke <= 5 && $urandom_range(0, 1) == 1)
                    begin
                        load_debruijn(ke, $urandom_range(0, (1 << ke) - 1));
                        if ($urandom_range(0, 4) == 0)
                        begin
                            if ($urandom_range(0, 1) == 1)
                            begin
                                cut = $urandom_range(0, pattern.size() - 1);
                                pattern[cut] = !pattern[cut];
                            end
                            else
                            begin
                                cut = $urandom_range(1, pattern.size());
                                while (pattern.size() > cut)
                                    void'(pattern.pop_back());
                            end
                        end
                    end
                    else
                    begin
                        pattern.delete();
                        repeat ($urandom_range(1, 2 * ke + 6))
                            pattern.push_back(1'($urandom));
                    end
                    send_pattern();
                    phase_bits += pattern.size();
                end
            end
        end
    endtask

    task automatic test_longest_code();
        set_idle_mode(3);
        set_code_length(4'(MAX_CODE_LEN_DEF));
        load_debruijn(MAX_CODE_LEN_DEF, $urandom_range(0, MAP_DEPTH - 1));
        send_pattern();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        bits_if.valid = 1'b0;
        bits_if.data_bit = 1'b0;
        bits_if.end_of_string = 1'b0;
        res_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        results_checked = 0;
        bits_sent = 0;
        strings_sent = 0;
        cycle_count = 0;
        code_len = CODE_LEN_W'(CODE_LEN_RESET);
        clear_tracker();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_zero_length();
        test_length_saturation();
        test_short_and_full();
        test_mid_string_change();
        test_random_traffic();
        test_longest_code();
        settle();

        $display("Sent %0d bits in %0d strings, code lengths 0 to 15, four flow-control mixes.",
                 bits_sent, strings_sent);
        $display("Compared %0d verdicts, including full coverage at the longest code length.",
                 results_checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
